[hdl/afcm_pkg.sv]
// Shared types, constants and helpers of the aspect-fit coordinate mapper.
// Depends on nothing; the top level, afcm_setup and afcm_cell import it.
`timescale 1ns / 1ps

package afcm_pkg;

	localparam int DIM_W                 = 15;
	localparam int COORD_W               = 16;
	localparam int EDGE_W                = 18;
	localparam int REG_IDX_W             = 3;
	localparam int INTEGER_SCALING_DEF   = 0;
	localparam int SCALE_FRAC_BITS_DEF   = 16;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REAL_WIDTH,
		REG_REAL_HEIGHT,
		REG_REAL_LEFT,
		REG_REAL_TOP,
		REG_USER_WIDTH,
		REG_USER_HEIGHT,
		REG_USER_LEFT,
		REG_USER_TOP
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]   real_width;
		logic [DIM_W-1:0]   real_height;
		logic [COORD_W-1:0] real_left;
		logic [COORD_W-1:0] real_top;
		logic [DIM_W-1:0]   user_width;
		logic [DIM_W-1:0]   user_height;
		logic [COORD_W-1:0] user_left;
		logic [COORD_W-1:0] user_top;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_START,
		ST_LOAD_A,
		ST_DIV_A,
		ST_MID,
		ST_LOAD_B,
		ST_DIV_B,
		ST_FIN,
		ST_OFS,
		ST_DONE
	} setup_state_t;

	// Side data that travels with a point down the divider chain.
	typedef struct packed {
		logic               mode;
		logic               hit;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [COORD_W-1:0] res0_x;
		logic [COORD_W-1:0] res0_y;
		logic               neg_x;
		logic               neg_y;
		logic               zero_scale;
	} pay_t;

	function automatic logic [COORD_W-1:0] sat16(input logic signed [33:0] v);
		logic [COORD_W-1:0] r;
		if (v > 34'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -34'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/afcm_if.sv]
// Valid/ready channel interfaces of the aspect-fit coordinate mapper.
// Point channel in, mapped point channel out; no dependencies.
`timescale 1ns / 1ps

interface afcm_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] point_x;
	logic [15:0] point_y;

	modport source(output valid, mode, point_x, point_y, input ready);
	modport sink(input valid, mode, point_x, point_y, output ready);
endinterface

interface afcm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] mapped_x;
	logic [15:0] mapped_y;
	logic        hit;

	modport source(output valid, mapped_x, mapped_y, hit, input ready);
	modport sink(input valid, mapped_x, mapped_y, hit, output ready);
endinterface

[hdl/aspect_fit_coordinate_mapper.sv]
// Top level of the aspect-fit coordinate mapper: registers, front stages,
// divider cell chain and output register. Depends on afcm_pkg, afcm_if,
// afcm_setup and afcm_cell.
`timescale 1ns / 1ps

// The mapper takes one point per clock while setup is done and the output is
// not stalled, and returns one mapped word per point, in order, through two
// front stages, one division cell per quotient bit (17 + SCALE_FRAC_BITS of
// them) and the output register. Scale and image offsets are derived from the
// geometry registers by a shared bit-serial divider after reset and after
// every register write, and input ready stays low until that is done.
// Registers may only be written while no point is in flight, since words
// already inside the chain use the current geometry.
module aspect_fit_coordinate_mapper import afcm_pkg::*; #(
	parameter int INTEGER_SCALING = INTEGER_SCALING_DEF,
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	afcm_in_if.sink              item_in,
	afcm_out_if.source           item_out
);

	localparam int F   = SCALE_FRAC_BITS;
	localparam int SW  = DIM_W + F;
	localparam int DW  = 17 + F;
	localparam int PRW = DIM_W + SW;

	cfg_t                     cfg_q;
	logic                     setup_done;
	logic [SW-1:0]            scale;
	logic signed [EDGE_W-1:0] tl_x, tl_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_width  <= 15'd1920;
			cfg_q.real_height <= 15'd1080;
			cfg_q.real_left   <= '0;
			cfg_q.real_top    <= '0;
			cfg_q.user_width  <= 15'd1920;
			cfg_q.user_height <= 15'd1080;
			cfg_q.user_left   <= '0;
			cfg_q.user_top    <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_REAL_WIDTH:  cfg_q.real_width  <= cfg_data[DIM_W-1:0];
				REG_REAL_HEIGHT: cfg_q.real_height <= cfg_data[DIM_W-1:0];
				REG_REAL_LEFT:   cfg_q.real_left   <= cfg_data;
				REG_REAL_TOP:    cfg_q.real_top    <= cfg_data;
				REG_USER_WIDTH:  cfg_q.user_width  <= cfg_data[DIM_W-1:0];
				REG_USER_HEIGHT: cfg_q.user_height <= cfg_data[DIM_W-1:0];
				REG_USER_LEFT:   cfg_q.user_left   <= cfg_data;
				REG_USER_TOP:    cfg_q.user_top    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	afcm_setup #(
		.INTEGER_SCALING(INTEGER_SCALING),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(cfg_we),
		.cfg    (cfg_q),
		.done   (setup_done),
		.scale  (scale),
		.tl_x   (tl_x),
		.tl_y   (tl_y)
	);

	// Front stage 1: hit test and offset from the source origin.
	logic signed [EDGE_W-1:0] px_w, py_w, ul_w, ut_w, rl_w, rt_w;
	logic signed [EDGE_W-1:0] uw_w, uh_w, rw_w, rh_w;
	logic                     hit_in;
	logic signed [EDGE_W-1:0] dx_in, dy_in;

	assign px_w = $signed({{2{item_in.point_x[15]}}, item_in.point_x});
	assign py_w = $signed({{2{item_in.point_y[15]}}, item_in.point_y});
	assign ul_w = $signed({{2{cfg_q.user_left[15]}}, cfg_q.user_left});
	assign ut_w = $signed({{2{cfg_q.user_top[15]}}, cfg_q.user_top});
	assign rl_w = $signed({{2{cfg_q.real_left[15]}}, cfg_q.real_left});
	assign rt_w = $signed({{2{cfg_q.real_top[15]}}, cfg_q.real_top});
	assign uw_w = $signed({3'b0, cfg_q.user_width});
	assign uh_w = $signed({3'b0, cfg_q.user_height});
	assign rw_w = $signed({3'b0, cfg_q.real_width});
	assign rh_w = $signed({3'b0, cfg_q.real_height});

	always_comb begin
		if (item_in.mode) begin
			hit_in = (px_w >= rl_w) && (px_w < rl_w + rw_w)
				&& (py_w >= rt_w) && (py_w < rt_w + rh_w);
			dx_in  = px_w - tl_x;
			dy_in  = py_w - tl_y;
		end else begin
			hit_in = (px_w >= ul_w) && (px_w < ul_w + uw_w)
				&& (py_w >= ut_w) && (py_w < ut_w + uh_w);
			dx_in  = px_w - ul_w;
			dy_in  = py_w - ut_w;
		end
	end

	logic                     v_s1, mode_s1, hit_s1, rdy_s1, rdy_s2;
	logic [COORD_W-1:0]       px_s1, py_s1;
	logic signed [EDGE_W-1:0] dx_s1, dy_s1;

	assign rdy_s1        = !v_s1 || rdy_s2;
	assign item_in.ready = setup_done && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item_in.valid && setup_done;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			mode_s1 <= item_in.mode;
			hit_s1  <= hit_in;
			px_s1   <= item_in.point_x;
			py_s1   <= item_in.point_y;
			dx_s1   <= dx_in;
			dy_s1   <= dy_in;
		end
	end

	// Front stage 2: forward scaling result and dividend for the reverse map.
	logic [PRW-1:0]           prod_x, prod_y;
	logic [PRW:0]             prr_x, prr_y;
	logic signed [32:0]       sum_x, sum_y;
	logic [EDGE_W-1:0]        ndx, ndy;
	logic [DIM_W-1:0]         mag_x, mag_y;
	pay_t                     pay_in;
	logic [DW-1:0]            dvd_x_in, dvd_y_in;

	assign prod_x = dx_s1[DIM_W-1:0] * scale;
	assign prod_y = dy_s1[DIM_W-1:0] * scale;
	assign prr_x  = {1'b0, prod_x} + ((PRW + 1)'(1) << (F - 1));
	assign prr_y  = {1'b0, prod_y} + ((PRW + 1)'(1) << (F - 1));
	assign sum_x  = $signed({2'b0, prr_x[PRW:F]}) + $signed({{15{tl_x[EDGE_W-1]}}, tl_x});
	assign sum_y  = $signed({2'b0, prr_y[PRW:F]}) + $signed({{15{tl_y[EDGE_W-1]}}, tl_y});
	assign ndx    = EDGE_W'(-dx_s1);
	assign ndy    = EDGE_W'(-dy_s1);
	assign mag_x  = dx_s1[EDGE_W-1] ? ndx[DIM_W-1:0] : dx_s1[DIM_W-1:0];
	assign mag_y  = dy_s1[EDGE_W-1] ? ndy[DIM_W-1:0] : dy_s1[DIM_W-1:0];

	// Rounded quotient: (2 * |d| * 2^F + s) / (2 * s).
	assign dvd_x_in = {1'b0, mag_x, {(F + 1){1'b0}}} + {2'b0, scale};
	assign dvd_y_in = {1'b0, mag_y, {(F + 1){1'b0}}} + {2'b0, scale};

	always_comb begin
		pay_in.mode       = mode_s1;
		pay_in.hit        = hit_s1;
		pay_in.point_x    = px_s1;
		pay_in.point_y    = py_s1;
		pay_in.res0_x     = sat16({sum_x[32], sum_x});
		pay_in.res0_y     = sat16({sum_y[32], sum_y});
		pay_in.neg_x      = dx_s1[EDGE_W-1];
		pay_in.neg_y      = dy_s1[EDGE_W-1];
		pay_in.zero_scale = scale == '0;
	end

	logic          c_valid [DW+1];
	logic          c_ready [DW+1];
	pay_t          c_pay   [DW+1];
	logic [DW-1:0] c_rem_x [DW+1];
	logic [DW-1:0] c_dvd_x [DW+1];
	logic [DW-1:0] c_rem_y [DW+1];
	logic [DW-1:0] c_dvd_y [DW+1];
	logic [DW-1:0] divisor;

	assign divisor = {1'b0, scale, 1'b0};
	assign rdy_s2  = !c_valid[0] || c_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_valid[0] <= 1'b0;
		end else if (rdy_s2) begin
			c_valid[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			c_pay[0]   <= pay_in;
			c_rem_x[0] <= '0;
			c_rem_y[0] <= '0;
			c_dvd_x[0] <= dvd_x_in;
			c_dvd_y[0] <= dvd_y_in;
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_cell
		afcm_cell #(.DW(DW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.divisor (divisor),
			.up_valid(c_valid[k]),
			.up_ready(c_ready[k]),
			.up_pay  (c_pay[k]),
			.up_rem_x(c_rem_x[k]),
			.up_dvd_x(c_dvd_x[k]),
			.up_rem_y(c_rem_y[k]),
			.up_dvd_y(c_dvd_y[k]),
			.dn_valid(c_valid[k+1]),
			.dn_ready(c_ready[k+1]),
			.dn_pay  (c_pay[k+1]),
			.dn_rem_x(c_rem_x[k+1]),
			.dn_dvd_x(c_dvd_x[k+1]),
			.dn_rem_y(c_rem_y[k+1]),
			.dn_dvd_y(c_dvd_y[k+1])
		);
	end

	// Reverse map: add the user edge, clamp low first and high last.
	function automatic logic [COORD_W-1:0] map_back(
		input logic [DW-1:0]      q,
		input logic               neg,
		input logic               zs,
		input logic [COORD_W-1:0] edge_v,
		input logic [DIM_W-1:0]   size
	);
		logic signed [EDGE_W-1:0] lo, hi, val;
		lo = $signed({{2{edge_v[15]}}, edge_v});
		hi = lo + $signed({3'b0, size}) - 18'sd1;
		if (neg || zs) begin
			val = lo;
		end else if (q >= DW'(size)) begin
			val = hi;
		end else begin
			val = lo + $signed({3'b0, q[DIM_W-1:0]});
		end
		if (val > hi) begin
			val = hi;
		end
		return sat16({{16{val[EDGE_W-1]}}, val});
	endfunction

	pay_t               pay_l;
	logic [COORD_W-1:0] fin_x, fin_y;
	logic               rdy_o, v_o_q, hit_o_q;
	logic [COORD_W-1:0] mx_o_q, my_o_q;

	assign pay_l = c_pay[DW];

	always_comb begin
		if (!pay_l.hit) begin
			fin_x = pay_l.point_x;
			fin_y = pay_l.point_y;
		end else if (pay_l.mode) begin
			fin_x = map_back(c_dvd_x[DW], pay_l.neg_x, pay_l.zero_scale,
				cfg_q.user_left, cfg_q.user_width);
			fin_y = map_back(c_dvd_y[DW], pay_l.neg_y, pay_l.zero_scale,
				cfg_q.user_top, cfg_q.user_height);
		end else begin
			fin_x = pay_l.res0_x;
			fin_y = pay_l.res0_y;
		end
	end

	assign rdy_o       = !v_o_q || item_out.ready;
	assign c_ready[DW] = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (rdy_o) begin
			v_o_q <= c_valid[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && c_valid[DW]) begin
			mx_o_q  <= fin_x;
			my_o_q  <= fin_y;
			hit_o_q <= pay_l.hit;
		end
	end

	assign item_out.valid    = v_o_q;
	assign item_out.mapped_x = mx_o_q;
	assign item_out.mapped_y = my_o_q;
	assign item_out.hit      = hit_o_q;

`ifndef SYNTHESIS
	a_cfg_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !item_in.ready)
		else $error("input taken right after a register write");

	a_setup_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(setup_done && !cfg_we) |=> setup_done)
		else $error("setup result dropped without a register write");

	a_fwd_hit_attached: assert property (@(posedge clk) disable iff (!arst_n)
		(c_valid[DW] && pay_l.hit && !pay_l.mode)
		|-> (cfg_q.user_width != '0 && cfg_q.user_height != '0))
		else $error("forward map hit with detached user rectangle");
`endif

endmodule

[hdl/afcm_setup.sv]
// Derives scale and image offsets from the geometry registers with a
// radix-2 sequential divider. Depends on afcm_pkg.
`timescale 1ns / 1ps

module afcm_setup import afcm_pkg::*; #(
	parameter int INTEGER_SCALING = INTEGER_SCALING_DEF,
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  cfg_t                              cfg,
	output logic                              done,
	output logic [DIM_W+SCALE_FRAC_BITS-1:0]  scale,
	output logic signed [EDGE_W-1:0]          tl_x,
	output logic signed [EDGE_W-1:0]          tl_y
);

	localparam int F     = SCALE_FRAC_BITS;
	localparam int SW    = DIM_W + F;
	localparam int CDW   = (17 + F > 32) ? 17 + F : 32;
	localparam int DSW   = 16;
	localparam int CNT_W = $clog2(CDW);

	setup_state_t state_q, state_d;

	logic [29:0]              prod_a_q, prod_b_q;
	logic                     fit_q, neg_q;
	logic signed [33:0]       nt_q;
	logic [DIM_W-1:0]         qa_q, s_q;
	logic [CDW-1:0]           dvd_q;
	logic [DSW-1:0]           rem_q, dsr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SW-1:0]            scale_q;
	logic signed [EDGE_W-1:0] tlx_q, tly_q;

	logic                     detached, fit_now, take, last_step;
	logic [DIM_W-1:0]         d_now, d_fit, base_now, qb, s_min;
	logic [DSW:0]             shifted, diff;
	logic [DSW-1:0]           rem_next;
	logic [COORD_W-1:0]       edge_sel;
	logic [29:0]              num_sel, us_x, us_y;
	logic signed [33:0]       nt_next, nt_mag;
	logic [16:0]              q17;
	logic signed [EDGE_W-1:0] off, ox_sum, oy_sum;

	function automatic logic signed [EDGE_W-1:0] half_trunc(input logic signed [EDGE_W-1:0] v);
		logic [EDGE_W-1:0] mag;
		mag = v[EDGE_W-1] ? EDGE_W'(-v) : v;
		mag = mag >> 1;
		return v[EDGE_W-1] ? -$signed(mag) : $signed(mag);
	endfunction

	assign detached  = (cfg.user_width == '0) || (cfg.user_height == '0);
	assign fit_now   = prod_a_q < prod_b_q;
	assign d_now     = fit_now ? cfg.user_width : cfg.user_height;
	assign base_now  = fit_now ? cfg.real_width : cfg.real_height;
	assign d_fit     = fit_q ? cfg.user_width : cfg.user_height;
	assign edge_sel  = fit_q ? cfg.real_top : cfg.real_left;
	assign num_sel   = fit_q ? (prod_b_q - prod_a_q) : (prod_a_q - prod_b_q);
	assign nt_next   = ($signed({17'b0, d_fit, 1'b0}) * $signed({{18{edge_sel[15]}}, edge_sel}))
		+ $signed({4'b0, num_sel});
	assign nt_mag    = nt_q[33] ? -nt_q : nt_q;

	assign shifted   = {rem_q, dvd_q[CDW-1]};
	assign take      = shifted >= {1'b0, dsr_q};
	assign diff      = shifted - {1'b0, dsr_q};
	assign rem_next  = take ? diff[DSW-1:0] : shifted[DSW-1:0];
	assign last_step = cnt_q == CNT_W'(CDW - 1);

	assign q17       = dvd_q[16:0];
	assign off       = neg_q ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
	assign qb        = dvd_q[DIM_W-1:0];
	assign s_min     = (qb < qa_q) ? qb : qa_q;
	assign us_x      = cfg.user_width * s_q;
	assign us_y      = cfg.user_height * s_q;
	assign ox_sum    = $signed({cfg.real_left[15], cfg.real_left, 1'b0})
		+ $signed({3'b0, cfg.real_width}) - $signed({3'b0, us_x[DIM_W-1:0]});
	assign oy_sum    = $signed({cfg.real_top[15], cfg.real_top, 1'b0})
		+ $signed({3'b0, cfg.real_height}) - $signed({3'b0, us_y[DIM_W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_START:  state_d = detached ? ST_DONE : ST_LOAD_A;
			ST_LOAD_A: state_d = ST_DIV_A;
			ST_DIV_A:  state_d = last_step ? ST_MID : ST_DIV_A;
			ST_MID:    state_d = ST_LOAD_B;
			ST_LOAD_B: state_d = ST_DIV_B;
			ST_DIV_B:  state_d = last_step ? ST_FIN : ST_DIV_B;
			ST_FIN:    state_d = (INTEGER_SCALING != 0) ? ST_OFS : ST_DONE;
			ST_OFS:    state_d = ST_DONE;
			ST_DONE:   state_d = ST_DONE;
			default:   state_d = ST_START;
		endcase
		if (restart) begin
			state_d = ST_START;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START: begin
				prod_a_q <= cfg.real_width * cfg.user_height;
				prod_b_q <= cfg.user_width * cfg.real_height;
				scale_q  <= '0;
				tlx_q    <= '0;
				tly_q    <= '0;
			end
			ST_LOAD_A: begin
				cnt_q <= '0;
				rem_q <= '0;
				fit_q <= fit_now;
				if (INTEGER_SCALING != 0) begin
					dvd_q <= CDW'(cfg.real_width);
					dsr_q <= {1'b0, cfg.user_width};
				end else begin
					dvd_q <= (CDW'(base_now) << (F + 1)) + CDW'(d_now);
					dsr_q <= {d_now, 1'b0};
				end
			end
			ST_DIV_A, ST_DIV_B: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[CDW-2:0], take};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_MID: begin
				if (INTEGER_SCALING != 0) begin
					qa_q <= dvd_q[DIM_W-1:0];
				end else begin
					scale_q <= dvd_q[SW-1:0];
					nt_q    <= nt_next;
				end
			end
			ST_LOAD_B: begin
				cnt_q <= '0;
				rem_q <= '0;
				if (INTEGER_SCALING != 0) begin
					dvd_q <= CDW'(cfg.real_height);
					dsr_q <= {1'b0, cfg.user_height};
				end else begin
					// The centering sum is divided as a magnitude and the sign put back.
					dvd_q <= CDW'(nt_mag[31:0]);
					dsr_q <= {d_fit, 1'b0};
					neg_q <= nt_q[33];
				end
			end
			ST_FIN: begin
				if (INTEGER_SCALING != 0) begin
					s_q     <= s_min;
					scale_q <= {s_min, {F{1'b0}}};
				end else if (fit_q) begin
					tlx_q <= $signed({{2{cfg.real_left[15]}}, cfg.real_left});
					tly_q <= off;
				end else begin
					tlx_q <= off;
					tly_q <= $signed({{2{cfg.real_top[15]}}, cfg.real_top});
				end
			end
			ST_OFS: begin
				tlx_q <= half_trunc(ox_sum);
				tly_q <= half_trunc(oy_sum);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done  = state_q == ST_DONE;
	assign scale = scale_q;
	assign tl_x  = tlx_q;
	assign tl_y  = tly_q;

endmodule

[hdl/afcm_cell.sv]
// One restoring-division step for the x and y lanes, with its own
// valid/ready stage register. Depends on afcm_pkg.
`timescale 1ns / 1ps

module afcm_cell import afcm_pkg::*; #(
	parameter int DW = 17 + SCALE_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [DW-1:0] divisor,
	input  logic          up_valid,
	output logic          up_ready,
	input  pay_t          up_pay,
	input  logic [DW-1:0] up_rem_x,
	input  logic [DW-1:0] up_dvd_x,
	input  logic [DW-1:0] up_rem_y,
	input  logic [DW-1:0] up_dvd_y,
	output logic          dn_valid,
	input  logic          dn_ready,
	output pay_t          dn_pay,
	output logic [DW-1:0] dn_rem_x,
	output logic [DW-1:0] dn_dvd_x,
	output logic [DW-1:0] dn_rem_y,
	output logic [DW-1:0] dn_dvd_y
);

	logic          valid_q;
	pay_t          pay_q;
	logic [DW-1:0] rem_x_q, dvd_x_q, rem_y_q, dvd_y_q;
	logic [DW:0]   sh_x, sh_y, df_x, df_y;
	logic          tk_x, tk_y;

	assign sh_x = {up_rem_x, up_dvd_x[DW-1]};
	assign sh_y = {up_rem_y, up_dvd_y[DW-1]};
	assign df_x = sh_x - {1'b0, divisor};
	assign df_y = sh_y - {1'b0, divisor};
	assign tk_x = sh_x >= {1'b0, divisor};
	assign tk_y = sh_y >= {1'b0, divisor};

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			pay_q   <= up_pay;
			rem_x_q <= tk_x ? df_x[DW-1:0] : sh_x[DW-1:0];
			rem_y_q <= tk_y ? df_y[DW-1:0] : sh_y[DW-1:0];
			dvd_x_q <= {up_dvd_x[DW-2:0], tk_x};
			dvd_y_q <= {up_dvd_y[DW-2:0], tk_y};
		end
	end

	assign dn_valid = valid_q;
	assign dn_pay   = pay_q;
	assign dn_rem_x = rem_x_q;
	assign dn_dvd_x = dvd_x_q;
	assign dn_rem_y = rem_y_q;
	assign dn_dvd_y = dvd_y_q;

endmodule
